// ===== hdl/hhlp_pkg.sv =====
package hhlp_pkg;

    // Table and field sizes
    localparam int HEADER_LIMIT = 32;
    localparam int NAME_LIMIT   = 64;
    localparam int VALUE_LIMIT  = 256;

    localparam int CNT_W  = $clog2(HEADER_LIMIT + 1);
    localparam int NLEN_W = $clog2(NAME_LIMIT);
    localparam int VLEN_W = $clog2(VALUE_LIMIT);
    localparam int SLOT_W = 6;

    // Queue between front and back (power of two depth)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Characters of interest
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_VALUE   = 2'd1,
        KIND_COMMIT  = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_request;
        logic       end_of_buffer;
    } byte_item_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } hdr_item_t;

    // One result without its last flag
    typedef struct packed {
        logic [7:0]        out_byte;
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
    } res_t;

    // All results of one byte: n is 1 or 2 once queued
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } entry_t;

endpackage

// ===== hdl/hhlp_front.sv =====
module hhlp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hhlp_pkg::byte_item_t byte_item,
    input  logic                q_full,
    output logic                q_push,
    output hhlp_pkg::entry_t    q_entry
);

    typedef struct packed {
        logic                        colon;
        logic                        skip;
        logic [hhlp_pkg::NLEN_W-1:0] nlen;
        logic [hhlp_pkg::VLEN_W-1:0] vlen;
    } line_t;

    typedef struct packed {
        line_t           l;
        logic            hit;
        hhlp_pkg::kind_t k;
    } take_t;

    // Route one ordinary character to name or value, or swallow it
    function automatic take_t take_char(input line_t l, input logic [7:0] c);
        take_t t;
        t.l   = l;
        t.hit = 1'b0;
        t.k   = hhlp_pkg::KIND_NAME;
        if (!l.colon) begin
            if (c == hhlp_pkg::CH_COLON) begin
                t.l.colon = 1'b1;
                t.l.skip  = 1'b1;
            end else if (l.nlen < hhlp_pkg::NLEN_W'(hhlp_pkg::NAME_LIMIT - 1)) begin
                t.l.nlen = l.nlen + hhlp_pkg::NLEN_W'(1);
                t.hit    = 1'b1;
            end
        end else if (!(l.skip && c == hhlp_pkg::CH_SPACE)) begin
            t.l.skip = 1'b0;
            if (l.vlen < hhlp_pkg::VLEN_W'(hhlp_pkg::VALUE_LIMIT - 1)) begin
                t.l.vlen = l.vlen + hhlp_pkg::VLEN_W'(1);
                t.hit    = 1'b1;
                t.k      = hhlp_pkg::KIND_VALUE;
            end
        end
        return t;
    endfunction

    function automatic hhlp_pkg::res_t mk_res(input logic [7:0] b, input hhlp_pkg::kind_t k,
                                             input logic [hhlp_pkg::CNT_W-1:0] cnt);
        hhlp_pkg::res_t r;
        r.out_byte = b;
        r.kind     = k;
        r.slot     = hhlp_pkg::SLOT_W'(cnt);
        return r;
    endfunction

    // Append a result to the byte's entry
    function automatic hhlp_pkg::entry_t put(input hhlp_pkg::entry_t e, input hhlp_pkg::res_t r);
        hhlp_pkg::entry_t o;
        o = e;
        if (e.n == 2'd0) begin
            o.r0 = r;
        end else begin
            o.r1 = r;
        end
        o.n = e.n + 2'd1;
        return o;
    endfunction

    logic                       in_req_reg, in_req_next;
    logic                       held_reg, held_next;
    line_t                      line_reg, line_next;
    logic [hhlp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    hhlp_pkg::entry_t           ent;
    take_t                      tc_cr, tc_b;
    logic [7:0]                 b;
    logic                       accept;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;
    assign b          = byte_item.data_byte;

    always_comb
    begin
        in_req_next = in_req_reg;
        held_next   = held_reg;
        line_next   = line_reg;
        cnt_next    = cnt_reg;
        ent         = '0;
        tc_cr       = '0;
        tc_b        = '0;

        // New buffer: drop any open header line with the old slot
        if (byte_item.start_of_request) begin
            if (!in_req_next && (line_next.colon || held_next || line_next.nlen != '0)) begin
                ent = put(ent, mk_res(8'd0, hhlp_pkg::KIND_DISCARD, cnt_next));
            end
            line_next   = '0;
            held_next   = 1'b0;
            cnt_next    = '0;
            in_req_next = 1'b1;
        end

        if (in_req_next) begin
            if (b == hhlp_pkg::CH_LF) begin
                in_req_next = 1'b0;
                line_next   = '0;
                held_next   = 1'b0;
            end
        end else if (byte_item.end_of_buffer && b != hhlp_pkg::CH_LF) begin
            ent       = put(ent, mk_res(8'd0, hhlp_pkg::KIND_DISCARD, cnt_next));
            line_next = '0;
            held_next = 1'b0;
        end else begin
            // A held CR not followed by LF is an ordinary character
            if (held_next) begin
                held_next = 1'b0;
                if (b != hhlp_pkg::CH_LF) begin
                    tc_cr     = take_char(line_next, hhlp_pkg::CH_CR);
                    line_next = tc_cr.l;
                    if (tc_cr.hit) begin
                        ent = put(ent, mk_res(hhlp_pkg::CH_CR, tc_cr.k, cnt_next));
                    end
                end
            end
            if (b == hhlp_pkg::CH_LF) begin
                if (line_next.colon && cnt_next < hhlp_pkg::CNT_W'(hhlp_pkg::HEADER_LIMIT)) begin
                    ent      = put(ent, mk_res(8'd0, hhlp_pkg::KIND_COMMIT, cnt_next));
                    cnt_next = cnt_next + hhlp_pkg::CNT_W'(1);
                end else begin
                    ent = put(ent, mk_res(8'd0, hhlp_pkg::KIND_DISCARD, cnt_next));
                end
                line_next = '0;
                held_next = 1'b0;
            end else if (b == hhlp_pkg::CH_CR) begin
                held_next      = 1'b1;
                line_next.skip = 1'b0;
            end else begin
                tc_b      = take_char(line_next, b);
                line_next = tc_b.l;
                if (tc_b.hit) begin
                    ent = put(ent, mk_res(b, tc_b.k, cnt_next));
                end
            end
        end

        // End of buffer: back to request-line state, count kept
        if (byte_item.end_of_buffer) begin
            in_req_next = 1'b1;
            line_next   = '0;
            held_next   = 1'b0;
        end
    end

    assign q_push  = accept && ent.n != 2'd0;
    assign q_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_req_reg <= 1'b1;
            held_reg   <= 1'b0;
            line_reg   <= '0;
            cnt_reg    <= '0;
        end else if (accept) begin
            in_req_reg <= in_req_next;
            held_reg   <= held_next;
            line_reg   <= line_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_req_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_req_reg |-> (!line_reg.colon && !held_reg && line_reg.nlen == '0))
        else $error("line state not cleared in request line");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hhlp_pkg::CNT_W'(hhlp_pkg::HEADER_LIMIT))
        else $error("header count above limit");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cnt_reg))
        else $error("header count moved without a transaction");

endmodule

// ===== hdl/hhlp_queue.sv =====
module hhlp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hhlp_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output hhlp_pkg::entry_t head
);

    hhlp_pkg::entry_t          mem [hhlp_pkg::Q_DEPTH];
    logic [hhlp_pkg::Q_AW-1:0] wr_ptr_reg;
    logic [hhlp_pkg::Q_AW-1:0] rd_ptr_reg;
    logic [hhlp_pkg::Q_CW-1:0] count_reg;

    assign full     = count_reg == hhlp_pkg::Q_CW'(hhlp_pkg::Q_DEPTH);
    assign nonempty = count_reg != '0;
    assign head     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + hhlp_pkg::Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + hhlp_pkg::Q_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + hhlp_pkg::Q_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - hhlp_pkg::Q_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("pop from empty queue");

    a_head_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nonempty |-> head.n != 2'd0)
        else $error("queued entry carries no result");

endmodule

// ===== hdl/hhlp_back.sv =====
module hhlp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hhlp_pkg::entry_t   q_head,
    output logic               q_pop,
    output logic               hdr_valid,
    input  logic               hdr_stall,
    output hhlp_pkg::hdr_item_t hdr_item
);

    hhlp_pkg::entry_t cur_reg;
    logic             cur_valid_reg;
    logic             sel_reg;
    logic             out_take;
    logic             done;
    logic             load;
    hhlp_pkg::res_t   res;

    assign out_take = cur_valid_reg && !hdr_stall;
    assign done     = sel_reg || cur_reg.n != 2'd2;
    assign load     = !cur_valid_reg || (out_take && done);
    assign q_pop    = q_valid && load;

    assign res               = sel_reg ? cur_reg.r1 : cur_reg.r0;
    assign hdr_valid         = cur_valid_reg;
    assign hdr_item.out_byte = res.out_byte;
    assign hdr_item.kind     = res.kind;
    assign hdr_item.slot     = res.slot;
    assign hdr_item.last     = done;

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end else if (out_take && !done) begin
            sel_reg <= 1'b1;
        end else if (load) begin
            cur_valid_reg <= q_valid;
            sel_reg       <= 1'b0;
        end
    end

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_valid && !hdr_stall && !hdr_item.last) |=> (hdr_valid && hdr_item.last))
        else $error("second result of a byte missing");

    a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !cur_valid_reg) |-> q_pop)
        else $error("idle back end left queue waiting");

    a_sel_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && sel_reg) |-> cur_reg.n == 2'd2)
        else $error("second result selected on single-result entry");

endmodule

// ===== hdl/http_header_line_parser_core.sv =====
// Path: an accepted byte's results go into the queue memory, then into the back
// end's current-entry register. Throughput: one byte per cycle while the queue is
// not full; a byte's two results leave in turn, the four-entry queue holding the extra.
// Reset (rst_n, asynchronous, active low): request-line state, header count zero,
// queue and output empty.
module http_header_line_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // byte channel
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  hhlp_pkg::byte_item_t byte_item,
    // header result channel
    output logic                 hdr_valid,
    input  logic                 hdr_stall,
    output hhlp_pkg::hdr_item_t  hdr_item
);

    // Front to queue: one entry per byte that yields any result
    logic             push;
    hhlp_pkg::entry_t push_entry;
    logic             q_full;

    // Queue to back
    logic             q_nonempty;
    logic             q_pop;
    hhlp_pkg::entry_t q_head;

    // Classify each byte, track line state and header count, stall only on a
    // full queue so the front keeps taking bytes while results wait.
    hhlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (push),
        .q_entry    (push_entry)
    );

    // Hold up to four byte transactions' worth of results between the halves.
    hhlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head       (q_head)
    );

    // Serialise each entry's one or two results onto the output, flagging the
    // final one of each byte as last.
    hhlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_item  (hdr_item)
    );

endmodule
